/* hw/rtl/okvt_pkg.sv */
// Shared field widths and command codes of the ordered key-value table.
package okvt_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // Command codes; the two remaining codes are treated as no-ops.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_UPDATE   = 3'd1,
    CMD_UPSERT   = 3'd2,
    CMD_ERASE    = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_READ_POS = 3'd5
  } cmd_e;

endpackage

/* hw/rtl/okvt_in_if.sv */
// Command channel of the ordered key-value table.
interface okvt_in_if;
  logic                            valid;
  logic                            ready;
  logic [okvt_pkg::CMD_W-1:0]      command;
  logic [okvt_pkg::KEY_W-1:0]      key;
  logic [okvt_pkg::VALUE_W-1:0]    value;
  logic [okvt_pkg::POS_W-1:0]      position;

  modport source (output valid, output command, output key, output value,
                  output position, input ready);
  modport sink   (input valid, input command, input key, input value,
                  input position, output ready);
endinterface

/* hw/rtl/okvt_out_if.sv */
// Result channel of the ordered key-value table.
interface okvt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            success;
  logic                            refused_full;
  logic [okvt_pkg::KEY_W-1:0]      out_key;
  logic [okvt_pkg::VALUE_W-1:0]    out_value;
  logic [okvt_pkg::COUNT_W-1:0]    entry_count;
  logic                            is_empty;

  modport source (output valid, output success, output refused_full, output out_key,
                  output out_value, output entry_count, output is_empty, input ready);
  modport sink   (input valid, input success, input refused_full, input out_key,
                  input out_value, input entry_count, input is_empty, output ready);
endinterface

/* hw/rtl/ordered_key_value_table.sv */
// Top level of the ordered key-value table: sequencer, key comparator and storage.
//
// Usage: commands arrive on the req_i channel (command, key, value, position) and
// each one yields exactly one result transaction on rsp_o (success, refused_full,
// out_key, out_value, entry_count, is_empty). Both channels use valid/ready.
// Entries are kept in insertion order in a single-port-read, single-port-write
// memory; one key comparator walks them from the oldest, one entry per cycle,
// with the read of each entry issued in the cycle before its compare.
// Flow: a key command compares the held entries from the oldest until its key
// matches or all are compared (up to CAPACITY). An erase that finds its key at
// entry s then closes up the later entries, one move per cycle through the same
// memory ports. A read at position reads the memory only when in range; an
// out-of-range read and an unknown command finish without a memory access. A new
// command is taken in the cycle after the previous result is loaded, not before.
// Reset empties the table at once (the entry count goes to zero); no clearing
// pass runs. When the receiver stalls, the finished result waits in the output
// register and one more command may be accepted and processed; it then waits
// for the output register to free before finishing.
module ordered_key_value_table #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  okvt_in_if.sink     req_i,
  okvt_out_if.source  rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = KEY_BITS + VALUE_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_SHIFT   = 6'b000100,
    ST_POS_RD  = 6'b001000,
    ST_POS_CAP = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic                         pend_q, pend_d;
  logic [AW-1:0]                pidx_q, pidx_d;
  logic [okvt_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [KEY_BITS-1:0]          key_q, key_d;
  logic [VALUE_BITS-1:0]        val_q, val_d;
  logic [okvt_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                         ok_q, ok_d;
  logic                         full_q, full_d;
  logic [okvt_pkg::KEY_W-1:0]   okey_q, okey_d;
  logic [okvt_pkg::VALUE_W-1:0] oval_q, oval_d;

  // Output register.
  logic                         ov_q, ov_d;
  logic                         o_ok_q;
  logic                         o_full_q;
  logic [okvt_pkg::KEY_W-1:0]   o_key_q;
  logic [okvt_pkg::VALUE_W-1:0] o_val_q;
  logic [okvt_pkg::COUNT_W-1:0] o_cnt_q;
  logic                         o_empty_q;
  logic                         o_load;

  // Memory port signals.
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [DW-1:0]                wdata;
  logic                         re;
  logic [AW-1:0]                raddr;
  logic [DW-1:0]                rdata;
  logic [KEY_BITS-1:0]          rd_key;
  logic [VALUE_BITS-1:0]        rd_val;
  logic                         hit;
  logic                         more;

  okvt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key = rdata[DW-1 -: KEY_BITS];
  assign rd_val = rdata[VALUE_BITS-1:0];

  // The comparator: the entry read last cycle against the command key.
  assign hit  = pend_q && (rd_key == key_q);
  assign more = idx_q < count_q;

  assign req_i.ready = (state_q == ST_IDLE);

  // Sequencer and memory control.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    val_d   = val_q;
    pos_d   = pos_q;
    ok_d    = ok_q;
    full_d  = full_q;
    okey_d  = okey_q;
    oval_d  = oval_q;
    we      = 1'b0;
    waddr   = pidx_q;
    wdata   = {key_q, val_q};
    re      = 1'b0;
    raddr   = idx_q[AW-1:0];
    o_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d  = req_i.command;
          key_d  = KEY_BITS'(req_i.key);
          val_d  = VALUE_BITS'(req_i.value);
          pos_d  = req_i.position;
          ok_d   = 1'b0;
          full_d = 1'b0;
          okey_d = okvt_pkg::KEY_W'(KEY_BITS'(req_i.key));
          oval_d = '0;
          idx_d  = '0;
          unique case (req_i.command)
            okvt_pkg::CMD_INSERT,
            okvt_pkg::CMD_UPDATE,
            okvt_pkg::CMD_UPSERT,
            okvt_pkg::CMD_ERASE,
            okvt_pkg::CMD_LOOKUP: begin
              state_d = ST_SCAN;
            end
            okvt_pkg::CMD_READ_POS: begin
              if (int'(req_i.position) < int'(count_q)) begin
                state_d = ST_POS_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          // The key is held at entry pidx_q.
          state_d = ST_DONE;
          unique case (cmd_q)
            okvt_pkg::CMD_UPDATE,
            okvt_pkg::CMD_UPSERT: begin
              we    = 1'b1;
              waddr = pidx_q;
              ok_d  = 1'b1;
            end
            okvt_pkg::CMD_ERASE: begin
              ok_d    = 1'b1;
              idx_d   = CW'(pidx_q) + CW'(1);
              state_d = ST_SHIFT;
            end
            okvt_pkg::CMD_LOOKUP: begin
              ok_d   = 1'b1;
              oval_d = okvt_pkg::VALUE_W'(rd_val);
            end
            default: begin
              // An insert of a held key fails and changes nothing.
            end
          endcase
        end else if (more) begin
          // Fetch the next entry for comparison.
          re     = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else begin
          // The key is absent.
          state_d = ST_DONE;
          if ((cmd_q == okvt_pkg::CMD_INSERT) || (cmd_q == okvt_pkg::CMD_UPSERT)) begin
            if (count_q == CW'(CAPACITY)) begin
              full_d = 1'b1;
            end else begin
              we      = 1'b1;
              waddr   = AW'(count_q);
              count_d = count_q + CW'(1);
              ok_d    = 1'b1;
            end
          end
        end
      end

      ST_SHIFT: begin
        // Close up: entry i+1 read last cycle is written to entry i.
        if (pend_q) begin
          we    = 1'b1;
          waddr = AW'(pidx_q - AW'(1));
          wdata = rdata;
        end
        if (more) begin
          re     = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q[AW-1:0];
          idx_d  = idx_q + CW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_POS_RD: begin
        re      = 1'b1;
        raddr   = AW'(pos_q);
        state_d = ST_POS_CAP;
      end

      ST_POS_CAP: begin
        ok_d    = 1'b1;
        okey_d  = okvt_pkg::KEY_W'(rd_key);
        oval_d  = okvt_pkg::VALUE_W'(rd_val);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          o_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction is taken.
  always_comb begin
    ov_d = ov_q;
    if (o_load) begin
      ov_d = 1'b1;
    end else if (rsp_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // Command operands and result fields.
  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    ok_q   <= ok_d;
    full_q <= full_d;
    okey_q <= okey_d;
    oval_q <= oval_d;
  end

  // Output payload, loaded with the count after the command.
  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_ok_q    <= ok_q;
      o_full_q  <= full_q;
      o_key_q   <= okey_q;
      o_val_q   <= oval_q;
      o_cnt_q   <= okvt_pkg::COUNT_W'(count_q);
      o_empty_q <= (count_q == '0);
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.success      = o_ok_q;
  assign rsp_o.refused_full = o_full_q;
  assign rsp_o.out_key      = o_key_q;
  assign rsp_o.out_value    = o_val_q;
  assign rsp_o.entry_count  = o_cnt_q;
  assign rsp_o.is_empty     = o_empty_q;

endmodule

/* hw/rtl/okvt_ram.sv */
// Entry storage: one write port and one read port with registered read data.
module okvt_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and valid in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
